/* rtl/core/frgam_pkg.sv */
// Shared constants, codes and the small-code glyph lookup for the glyph address mapper.
package frgam_pkg;

    localparam int ADDR_W  = 24;
    localparam int CODE_W  = 16;
    localparam int BYTES_W = 6;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam logic [STAT_W-1:0] ST_READY  = 2'd0;
    localparam logic [STAT_W-1:0] ST_TABLE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR  = 2'd2;

    localparam logic [1:0] REG_SYMBOL_BASE = 2'd0;
    localparam logic [1:0] REG_HANZI_BASE  = 2'd1;
    localparam logic [1:0] REG_INDEX_BASE  = 2'd2;

    localparam logic [ADDR_W-1:0] SYMBOL_BASE_RST = 24'd36224;
    localparam logic [ADDR_W-1:0] HANZI_BASE_RST  = 24'd93452;
    localparam logic [ADDR_W-1:0] INDEX_BASE_RST  = 24'd87436;

    localparam logic [CODE_W-1:0] SMALL_LIMIT = 16'd45632;

    localparam logic [BYTES_W-1:0] BYTES_SMALL = 6'd16;
    localparam logic [BYTES_W-1:0] BYTES_LARGE = 6'd32;
    localparam logic [BYTES_W-1:0] BYTES_TABLE = 6'd2;
    localparam logic [BYTES_W-1:0] BYTES_NONE  = 6'd0;

    localparam logic [7:0] CELL_LO   = 8'hA1;
    localparam logic [7:0] CELL_HI   = 8'hFE;
    localparam logic [7:0] HANZI_ROW = 8'hB0;
    localparam logic [7:0] INDEX_ROW = 8'hD8;
    localparam logic [11:0] ROW_CELLS = 12'd94;

    function automatic logic in_span(input logic [CODE_W-1:0] c,
                                     input logic [CODE_W-1:0] lo,
                                     input logic [CODE_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // 16-byte glyph address for codes in the small range; 0 when unmapped
    function automatic logic [ADDR_W-1:0] small_glyph(input logic [CODE_W-1:0] c);
        logic [10:0] slot;
        logic        hit;
        slot = '0;
        hit  = 1'b1;
        if (in_span(c, 16'h0020, 16'h007F))      slot = 11'(c - 16'h0020);
        else if (in_span(c, 16'h00A0, 16'h00FF)) slot = 11'd96  + 11'(c - 16'h00A0);
        else if (in_span(c, 16'h0100, 16'h017F)) slot = 11'd192 + 11'(c - 16'h0100);
        else if (in_span(c, 16'h01A0, 16'h01CF)) slot = 11'd320 + 11'(c - 16'h01A0);
        else if (in_span(c, 16'h01F0, 16'h01FF)) slot = 11'd368 + 11'(c - 16'h01F0);
        else if (in_span(c, 16'h0210, 16'h021F)) slot = 11'd384 + 11'(c - 16'h0210);
        else if (in_span(c, 16'h1EA0, 16'h1EFF)) slot = 11'd400 + 11'(c - 16'h1EA0);
        else if (in_span(c, 16'h0370, 16'h03CF)) slot = 11'd496 + 11'(c - 16'h0370);
        else if (in_span(c, 16'h0400, 16'h045F)) slot = 11'd592 + 11'(c - 16'h0400);
        else if (in_span(c, 16'h0490, 16'h04FF)) slot = 11'd688 + 11'(c - 16'h0490);
        else if (in_span(c, 16'h0590, 16'h05FF)) slot = 11'd800 + 11'(c - 16'h0590);
        else if (in_span(c, 16'h0E00, 16'h0E7F)) slot = 11'd912 + 11'(c - 16'h0E00);
        else hit = 1'b0;
        return hit ? ADDR_W'({slot, 4'b0000}) : '0;
    endfunction

endpackage

/* rtl/core/font_rom_glyph_address_mapper_unit.sv */
// Glyph address mapper top level: input register, mapping logic, result register, APB registers.
//
//  channel | ports          | tdata (low bit up)                  | tuser
//  --------+----------------+-------------------------------------+---------------
//  input   | s_tvalid/ready | char_code[15:0], table_word[31:16]  | command
//  result  | m_tvalid/ready | rom_address[23:0], read_bytes[29:24]| status[1:0]
//  config  | APB            | symbol_base, hanzi_base, index base | -
//
// One transfer per cycle while the result side is not stalled by m_tready.
// The mapping is one combinational step between the input and result registers.
// A held result does not block the input register; s_tready falls only when both are full.
// Synchronous active-low reset clears valids and the pending-reply flag and loads the
// base registers with their reset values.
module font_rom_glyph_address_mapper_unit
    import frgam_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // char_code[15:0], table_word[31:16]
    input  logic               s_tuser,   // command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // rom_address[23:0], read_bytes[29:24], zero fill
    output logic [STAT_W-1:0]  m_tuser,   // status[1:0]
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ADDR_W-1:0] symbol_base_reg, hanzi_base_reg, index_base_reg;

    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [CODE_W-1:0] in_code_reg;
    logic [CODE_W-1:0] in_word_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [BYTES_W-1:0] out_bytes_reg;

    logic awaiting_reg;

    logic               advance;
    logic [STAT_W-1:0]  status_next;
    logic [ADDR_W-1:0]  addr_next;
    logic [BYTES_W-1:0] bytes_next;
    logic               awaiting_next;

    logic [7:0]  row, col;
    logic        cell_ok;
    logic [8:0]  sym_slot;
    logic        sym_hit;
    logic [5:0]  hz_row;
    logic [4:0]  ix_row;
    logic [11:0] hz_n, ix_n;
    logic        cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_base_reg <= SYMBOL_BASE_RST;
            hanzi_base_reg  <= HANZI_BASE_RST;
            index_base_reg  <= INDEX_BASE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SYMBOL_BASE: symbol_base_reg <= pwdata[ADDR_W-1:0];
                REG_HANZI_BASE:  hanzi_base_reg  <= pwdata[ADDR_W-1:0];
                REG_INDEX_BASE:  index_base_reg  <= pwdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SYMBOL_BASE: prdata = PDATA_W'(symbol_base_reg);
            REG_HANZI_BASE:  prdata = PDATA_W'(hanzi_base_reg);
            REG_INDEX_BASE:  prdata = PDATA_W'(index_base_reg);
            default:         prdata = '0;
        endcase
    end

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_code_reg <= s_tdata[15:0];
            in_word_reg <= s_tdata[31:16];
        end
    end

    // mapping
    assign row     = in_code_reg[15:8];
    assign col     = in_code_reg[7:0];
    assign cell_ok = (col >= CELL_LO) && (col <= CELL_HI);
    assign hz_row  = 6'(row - HANZI_ROW);
    assign ix_row  = 5'(row - INDEX_ROW);
    assign hz_n    = 12'(hz_row) * ROW_CELLS + 12'(col - CELL_LO) + 12'd1;
    assign ix_n    = 12'(ix_row) * ROW_CELLS + 12'(col - CELL_LO);

    always_comb begin
        sym_hit  = 1'b1;
        sym_slot = '0;
        if (row == 8'hA1 && col >= CELL_LO && col <= 8'hBF)      sym_slot = 9'(col - CELL_LO);
        else if (row == 8'hA3 && cell_ok)                        sym_slot = 9'd31 + 9'(col - CELL_LO);
        else if (row == 8'hA4 && col >= CELL_LO && col <= 8'hF3) sym_slot = 9'd125 + 9'(col - CELL_LO);
        else if (row == 8'hA5 && col >= CELL_LO && col <= 8'hF6) sym_slot = 9'd208 + 9'(col - CELL_LO);
        else sym_hit = 1'b0;
    end

    always_comb begin
        status_next   = ST_READY;
        addr_next     = '0;
        bytes_next    = BYTES_NONE;
        awaiting_next = awaiting_reg;
        if (in_cmd_reg == CMD_REPLY) begin
            if (awaiting_reg) begin
                addr_next     = hanzi_base_reg + ADDR_W'({in_word_reg, 5'b00000});
                bytes_next    = BYTES_LARGE;
                awaiting_next = 1'b0;
            end else begin
                status_next = ST_ERROR;
            end
        end else begin
            awaiting_next = 1'b0;
            if (in_code_reg <= SMALL_LIMIT) begin
                addr_next  = small_glyph(in_code_reg);
                bytes_next = BYTES_SMALL;
            end else begin
                bytes_next = BYTES_LARGE;
                if (row >= 8'hA1 && row <= 8'hA5) begin
                    addr_next = sym_hit ? symbol_base_reg + ADDR_W'({sym_slot, 5'b00000})
                                        : symbol_base_reg;
                end else if (row >= HANZI_ROW && row <= 8'hD7 && cell_ok) begin
                    addr_next = hanzi_base_reg + ADDR_W'({hz_n, 5'b00000});
                end else if (row >= INDEX_ROW && row <= 8'hF7 && cell_ok) begin
                    addr_next     = index_base_reg + ADDR_W'({ix_n, 1'b0});
                    status_next   = ST_TABLE;
                    bytes_next    = BYTES_TABLE;
                    awaiting_next = 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                awaiting_reg <= awaiting_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_status_reg <= status_next;
            out_addr_reg   <= addr_next;
            out_bytes_reg  <= bytes_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_bytes_reg, out_addr_reg};

endmodule

/* verif/tb.sv */
// Self-checking stream and APB testbench for the font ROM glyph address mapper.
module tb;
    import frgam_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 180;
    localparam int NUM_PHASES     = 6;
    localparam int LONG_HOLD      = 80;
    localparam int LONG_HOLD_AT   = 300;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  addr;
        logic [BYTES_W-1:0] nbytes;
    } glyph_rsp_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] word;
        logic              typed;
        glyph_rsp_t        rsp;
    } stim_row_t;

    localparam glyph_rsp_t NO_RSP = '{ST_READY, 24'd0, BYTES_NONE};

    localparam logic [1:0] REG_LIST [3] = '{REG_SYMBOL_BASE, REG_HANZI_BASE, REG_INDEX_BASE};

    // small-code spans: first code, last code, first 16-byte slot
    localparam logic [CODE_W-1:0] SPAN_LO [12] = '{
        16'h0020, 16'h00A0, 16'h0100, 16'h01A0, 16'h01F0, 16'h0210,
        16'h1EA0, 16'h0370, 16'h0400, 16'h0490, 16'h0590, 16'h0E00};
    localparam logic [CODE_W-1:0] SPAN_HI [12] = '{
        16'h007F, 16'h00FF, 16'h017F, 16'h01CF, 16'h01FF, 16'h021F,
        16'h1EFF, 16'h03CF, 16'h045F, 16'h04FF, 16'h05FF, 16'h0E7F};
    localparam logic [10:0] SPAN_SLOT [12] = '{
        11'd0, 11'd96, 11'd192, 11'd320, 11'd368, 11'd384,
        11'd400, 11'd496, 11'd592, 11'd688, 11'd800, 11'd912};

    localparam stim_row_t DIRECTED [27] = '{
        '{CMD_REPLY, 16'h0000, 16'hFFFF, 1'b1, '{ST_ERROR, 24'd0, BYTES_NONE}},
        '{CMD_MAP,   16'h0000, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'h0020, 16'hFFFF, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'h007F, 16'h0000, 1'b1, '{ST_READY, 24'd1520, BYTES_SMALL}},
        '{CMD_MAP,   16'h0590, 16'h0000, 1'b1, '{ST_READY, 24'd12800, BYTES_SMALL}},
        '{CMD_MAP,   16'h1EA0, 16'h0000, 1'b1, '{ST_READY, 24'd6400, BYTES_SMALL}},
        '{CMD_MAP,   16'h0E7F, 16'h0000, 1'b1, '{ST_READY, 24'd16624, BYTES_SMALL}},
        '{CMD_MAP,   16'h05FF, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'h0180, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hB240, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hB241, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_LARGE}},
        '{CMD_MAP,   16'hFFFF, 16'hFFFF, 1'b1, '{ST_READY, 24'd0, BYTES_LARGE}},
        '{CMD_MAP,   16'hA1A1, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hA2A1, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hA3FE, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'hA4F3, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'hA5F6, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'hA5F7, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hB0A1, 16'h0000, 1'b1, '{ST_READY, 24'd0, BYTES_SMALL}},
        '{CMD_MAP,   16'hD7FE, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'hD8A1, 16'h0000, 1'b1, '{ST_TABLE, 24'd87436, BYTES_TABLE}},
        '{CMD_REPLY, 16'hFFFF, 16'h0000, 1'b1, '{ST_READY, 24'd93452, BYTES_LARGE}},
        '{CMD_MAP,   16'hF7FE, 16'h0000, 1'b0, NO_RSP},
        '{CMD_MAP,   16'h0041, 16'h0000, 1'b0, NO_RSP},
        '{CMD_REPLY, 16'h0000, 16'h1234, 1'b1, '{ST_ERROR, 24'd0, BYTES_NONE}},
        '{CMD_MAP,   16'hE0A1, 16'h0000, 1'b0, NO_RSP},
        '{CMD_REPLY, 16'h0000, 16'hFFFF, 1'b0, NO_RSP}
    };

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;   // char_code[15:0], table_word[31:16]
    logic               s_tuser;   // command
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;   // rom_address[23:0], read_bytes[29:24], zero fill
    logic [STAT_W-1:0]  m_tuser;   // status[1:0]
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic [ADDR_W-1:0] sym_base;
    logic [ADDR_W-1:0] hz_base;
    logic [ADDR_W-1:0] idx_base;
    logic              reply_due;
    glyph_rsp_t        expected_glyphs[$];
    int                errors = 0;
    int                items_sent = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;
    logic              idle_on = 1'b1;

    font_rom_glyph_address_mapper_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic logic [ADDR_W-1:0] small_addr(input logic [CODE_W-1:0] code);
        logic [ADDR_W-1:0] a;
        a = '0;
        for (int i = 0; i < 12; i++)
            if (code >= SPAN_LO[i] && code <= SPAN_HI[i])
                a = (ADDR_W'(SPAN_SLOT[i]) + ADDR_W'(code - SPAN_LO[i])) << 4;
        return a;
    endfunction

    function automatic glyph_rsp_t map_glyph(input logic cmd, input logic [CODE_W-1:0] code,
                                             input logic [CODE_W-1:0] word);
        glyph_rsp_t        r;
        logic [7:0]        row;
        logic [7:0]        col;
        logic              cell_ok;
        logic              hit;
        logic [ADDR_W-1:0] slot;
        r       = NO_RSP;
        row     = code[15:8];
        col     = code[7:0];
        cell_ok = col >= CELL_LO && col <= CELL_HI;
        if (cmd == CMD_REPLY) begin
            if (reply_due) begin
                r.addr    = ADDR_W'(word) * 24'd32 + hz_base;
                r.nbytes  = BYTES_LARGE;
                reply_due = 1'b0;
            end else begin
                r.status = ST_ERROR;
            end
        end else begin
            reply_due = 1'b0;
            if (code <= SMALL_LIMIT) begin
                r.addr   = small_addr(code);
                r.nbytes = BYTES_SMALL;
            end else begin
                r.nbytes = BYTES_LARGE;
                slot     = ADDR_W'(col) - ADDR_W'(CELL_LO);
                if (row >= 8'hA1 && row <= 8'hA5) begin
                    hit = 1'b1;
                    if (row == 8'hA1 && col >= CELL_LO && col <= 8'hBF) slot = slot;
                    else if (row == 8'hA3 && cell_ok) slot = slot + 24'd31;
                    else if (row == 8'hA4 && col >= CELL_LO && col <= 8'hF3) slot = slot + 24'd125;
                    else if (row == 8'hA5 && col >= CELL_LO && col <= 8'hF6) slot = slot + 24'd208;
                    else hit = 1'b0;
                    r.addr = hit ? slot * 24'd32 + sym_base : sym_base;
                end else if (row >= HANZI_ROW && row < INDEX_ROW && cell_ok) begin
                    slot   = ADDR_W'(row - HANZI_ROW) * ADDR_W'(ROW_CELLS) + slot + 24'd1;
                    r.addr = slot * 24'd32 + hz_base;
                end else if (row >= INDEX_ROW && row <= 8'hF7 && cell_ok) begin
                    slot      = ADDR_W'(row - INDEX_ROW) * ADDR_W'(ROW_CELLS) + slot;
                    r.addr    = slot * 24'd2 + idx_base;
                    r.status  = ST_TABLE;
                    r.nbytes  = BYTES_TABLE;
                    reply_due = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic pause_sender();
        int n;
        n = idle_on ? gap_len() : 0;
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    task automatic offer_item(input logic cmd, input logic [CODE_W-1:0] code,
                              input logic [CODE_W-1:0] word, input logic typed,
                              input glyph_rsp_t given);
        glyph_rsp_t rsp;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {word, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rsp = map_glyph(cmd, code, word);
        expected_glyphs.push_back(typed ? given : rsp);
        items_sent++;
    endtask

    task automatic offer(input logic cmd, input logic [CODE_W-1:0] val);
        pause_sender();
        if (cmd == CMD_MAP) offer_item(cmd, val, 16'($urandom), 1'b0, NO_RSP);
        else offer_item(cmd, 16'($urandom), val, 1'b0, NO_RSP);
    endtask

    task automatic drain_all();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_glyphs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= {8'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (wr) begin
            case (idx)
                REG_SYMBOL_BASE: sym_base = val;
                REG_HANZI_BASE:  hz_base  = val;
                REG_INDEX_BASE:  idx_base = val;
                default: ;
            endcase
        end else if (prdata[ADDR_W-1:0] !== val) begin
            $error("prdata reg %0d: expected 0x%06h, actual 0x%06h", idx, val,
                   prdata[ADDR_W-1:0]);
            errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_sequence();
        int         kind;
        int         k;
        logic [7:0] row;
        logic [7:0] col;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            if ($urandom_range(0, 1) != 0) begin
                k = $urandom_range(0, 11);
                offer(CMD_MAP, 16'($urandom_range(SPAN_LO[k] - 1, SPAN_HI[k] + 1)));
            end else begin
                offer(CMD_MAP, 16'($urandom_range(0, SMALL_LIMIT)));
            end
        end else if (kind < 35) begin
            row = 8'($urandom_range(8'hA1, 8'hA5));
            col = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8'hA0, 8'hFF));
            offer(CMD_MAP, {row, col});
        end else if (kind < 55) begin
            row = 8'($urandom_range(HANZI_ROW, INDEX_ROW - 1));
            col = ($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'($urandom_range(CELL_LO, CELL_HI));
            offer(CMD_MAP, {row, col});
        end else if (kind < 80) begin
            row = 8'($urandom_range(INDEX_ROW, 8'hF7));
            col = 8'($urandom_range(CELL_LO, CELL_HI));
            offer(CMD_MAP, {row, col});
            k = $urandom_range(0, 9);
            if (k < 8) begin
                offer(CMD_REPLY, 16'($urandom));
            end else if (k == 8) begin
                offer(CMD_MAP, 16'($urandom));
            end else begin
                offer(CMD_REPLY, 16'($urandom));
                offer(CMD_REPLY, 16'($urandom));
            end
        end else if (kind < 90) begin
            offer(CMD_MAP, 16'($urandom));
        end else begin
            offer(CMD_REPLY, 16'($urandom));
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        glyph_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_glyphs.size() == 0) begin
                $error("unexpected transfer: status %0d rom_address 0x%06h read_bytes %0d",
                       m_tuser, m_tdata[23:0], m_tdata[29:24]);
                errors++;
            end else begin
                want = expected_glyphs.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[23:0] !== want.addr) begin
                    $error("rom_address: expected 0x%06h, actual 0x%06h", want.addr,
                           m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[29:24] !== want.nbytes) begin
                    $error("read_bytes: expected %0d, actual %0d", want.nbytes, m_tdata[29:24]);
                    errors++;
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result receiver
    initial begin
        int   hold_left;
        logic held_long;
        hold_left = 0;
        held_long = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_long && results_seen >= LONG_HOLD_AT) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                hold_left = gap_len();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [ADDR_W-1:0] cfg [3];
        int                start;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_MAP;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        aresetn   = 1'b0;
        sym_base  = SYMBOL_BASE_RST;
        hz_base   = HANZI_BASE_RST;
        idx_base  = INDEX_BASE_RST;
        reply_due = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            pause_sender();
            offer_item(DIRECTED[i].cmd, DIRECTED[i].code, DIRECTED[i].word,
                       DIRECTED[i].typed, DIRECTED[i].rsp);
        end
        drain_all();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: cfg = '{24'h000000, 24'h000000, 24'h000000};
                1: cfg = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
                3: cfg = '{SYMBOL_BASE_RST, HANZI_BASE_RST, INDEX_BASE_RST};
                default: cfg = '{24'($urandom), 24'($urandom), 24'($urandom)};
            endcase
            for (int r = 0; r < 3; r++) begin
                apb_xfer(1'b1, REG_LIST[r], cfg[r]);
                apb_xfer(1'b0, REG_LIST[r], cfg[r]);
            end
            idle_on = (p != 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) run_sequence();
            drain_all();
        end

        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/frgam_pkg.sv
rtl/core/font_rom_glyph_address_mapper_unit.sv
verif/tb.sv
